@@ rtl/core/obb_pkg.sv @@
// Shared constants, types and width helpers for the oriented box overlap test.
// Used by obb_rot, obb_proj, obb_overlap_test, obb_checker and tb. No dependencies.
`default_nettype none

package obb_pkg;

    // Default width of the rotated half-vector components
    localparam int COORD_BITS_DEF = 16;

    // Rotated components never exceed 16 signed bits after rounding
    localparam int VEC_BITS_MAX = 16;

    // Field widths
    localparam int COORD_W  = 16;   // signed Q12.4 coordinates
    localparam int DIR_W    = 16;   // signed Q1.14 direction
    localparam int SIZE_W   = 15;   // unsigned Q11.4 size
    localparam int EXT_W    = 14;   // unsigned Q10.4 extent registers
    localparam int CFG_IDX_W = 2;

    // Extent times direction: 15-bit signed by 16-bit signed
    localparam int PROD_W = EXT_W + 1 + DIR_W;
    // Doubled centre difference 2*ox + w - 2*cx
    localparam int DIFF_W = COORD_W + 3;
    // Rounding: drop the Q1.14 fraction, add half an LSB first
    localparam int FRAC_BITS = 14;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH = 2'd1;

    // Pipeline stage numbering
    localparam int NUM_STAGES = 6;
    localparam int ST_MUL   = 0;  // extent products, centre difference
    localparam int ST_RND   = 1;  // round and saturate half-vectors
    localparam int ST_PROJ  = 2;  // projection products
    localparam int ST_PAIR  = 3;  // dot products and magnitudes
    localparam int ST_SUM   = 4;  // radius sums and distance magnitudes
    localparam int ST_CMP   = 5;  // compare and output register

    // Stage load strobes from the pipeline control
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    // Width of the stored half-vector components
    function automatic int vec_bits(input int coord_bits);
        int res;
        res = (coord_bits < VEC_BITS_MAX) ? coord_bits : VEC_BITS_MAX;
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/obb_rot.sv @@
// Front end: rotates the configured extents by the input direction, rounds and
// saturates the half-vectors, and forms the doubled centre difference. Uses obb_pkg.
`default_nettype none

module obb_rot #(
    parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF
) (
    input  wire logic                                         clk,
    input  wire obb_pkg::pipe_ctrl_t                          ctrl,
    input  wire logic        [obb_pkg::EXT_W-1:0]             half_width,
    input  wire logic        [obb_pkg::EXT_W-1:0]             half_length,
    input  wire logic signed [obb_pkg::COORD_W-1:0]           box_center_x,
    input  wire logic signed [obb_pkg::COORD_W-1:0]           box_center_y,
    input  wire logic signed [obb_pkg::DIR_W-1:0]             dir_cos,
    input  wire logic signed [obb_pkg::DIR_W-1:0]             dir_sin,
    input  wire logic signed [obb_pkg::COORD_W-1:0]           other_left_x,
    input  wire logic signed [obb_pkg::COORD_W-1:0]           other_top_y,
    input  wire logic        [obb_pkg::SIZE_W-1:0]            other_width,
    input  wire logic        [obb_pkg::SIZE_W-1:0]            other_height,
    output logic signed [obb_pkg::vec_bits(COORD_BITS)-1:0]   ux,
    output logic signed [obb_pkg::vec_bits(COORD_BITS)-1:0]   uy,
    output logic signed [obb_pkg::vec_bits(COORD_BITS)-1:0]   vx,
    output logic signed [obb_pkg::vec_bits(COORD_BITS)-1:0]   vy,
    output logic signed [obb_pkg::DIFF_W-1:0]                 dx,
    output logic signed [obb_pkg::DIFF_W-1:0]                 dy,
    output logic        [obb_pkg::SIZE_W-1:0]                 w,
    output logic        [obb_pkg::SIZE_W-1:0]                 h
);

    localparam int VW = obb_pkg::vec_bits(COORD_BITS);
    localparam int PW = obb_pkg::PROD_W;
    localparam int QW = PW + 1;
    localparam int RW = QW - obb_pkg::FRAC_BITS;
    localparam int DW = obb_pkg::DIFF_W;
    localparam logic signed [RW-1:0] SatHi = RW'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] SatLo = -SatHi - RW'(1);
    localparam logic signed [QW-1:0] RoundHalf = QW'(64'sd1 <<< (obb_pkg::FRAC_BITS - 1));

    // Stage 1 registers
    logic signed [PW-1:0] pux_reg, puy_reg, pvx_reg, pvy_reg;
    logic signed [PW-1:0] pux_next, puy_next, pvx_next, pvy_next;
    logic signed [PW-1:0] ws_prod;
    logic signed [DW-1:0] dx1_reg, dy1_reg, dx1_next, dy1_next;
    logic [obb_pkg::SIZE_W-1:0] w1_reg, h1_reg;

    // Stage 2 registers
    logic signed [VW-1:0] ux_reg, uy_reg, vx_reg, vy_reg;
    logic signed [VW-1:0] ux_next, uy_next, vx_next, vy_next;
    logic signed [DW-1:0] dx2_reg, dy2_reg;
    logic [obb_pkg::SIZE_W-1:0] w2_reg, h2_reg;

    // Round half up to Q12.4, then clamp to VW signed bits
    function automatic logic signed [VW-1:0] rnd_sat(input logic signed [PW-1:0] p);
        logic signed [QW-1:0] q;
        logic signed [RW-1:0] r;
        logic signed [RW-1:0] c;
        q = QW'(p) + RoundHalf;
        r = $signed(q[QW-1:obb_pkg::FRAC_BITS]);
        if (r > SatHi)
        begin
            c = SatHi;
        end
        else if (r < SatLo)
        begin
            c = SatLo;
        end
        else
        begin
            c = r;
        end
        return c[VW-1:0];
    endfunction

    // Extent products and doubled centre difference
    always_comb
    begin
        pux_next = $signed({1'b0, half_length}) * dir_cos;
        puy_next = $signed({1'b0, half_length}) * dir_sin;
        ws_prod  = $signed({1'b0, half_width}) * dir_sin;
        pvx_next = -ws_prod;
        pvy_next = $signed({1'b0, half_width}) * dir_cos;
        dx1_next = (DW'(other_left_x) <<< 1) + $signed(DW'(other_width))
                 - (DW'(box_center_x) <<< 1);
        dy1_next = (DW'(other_top_y) <<< 1) + $signed(DW'(other_height))
                 - (DW'(box_center_y) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[obb_pkg::ST_MUL])
        begin
            pux_reg <= pux_next;
            puy_reg <= puy_next;
            pvx_reg <= pvx_next;
            pvy_reg <= pvy_next;
            dx1_reg <= dx1_next;
            dy1_reg <= dy1_next;
            w1_reg  <= other_width;
            h1_reg  <= other_height;
        end
    end

    // Round and saturate the half-vectors
    always_comb
    begin
        ux_next = rnd_sat(pux_reg);
        uy_next = rnd_sat(puy_reg);
        vx_next = rnd_sat(pvx_reg);
        vy_next = rnd_sat(pvy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[obb_pkg::ST_RND])
        begin
            ux_reg  <= ux_next;
            uy_reg  <= uy_next;
            vx_reg  <= vx_next;
            vy_reg  <= vy_next;
            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;
            w2_reg  <= w1_reg;
            h2_reg  <= h1_reg;
        end
    end

    assign ux = ux_reg;
    assign uy = uy_reg;
    assign vx = vx_reg;
    assign vy = vy_reg;
    assign dx = dx2_reg;
    assign dy = dy2_reg;
    assign w  = w2_reg;
    assign h  = h2_reg;

endmodule

`default_nettype wire

@@ rtl/core/obb_proj.sv @@
// Projection back end: projects all half-vectors and the centre difference onto
// each axis and forms radius sums and distances over three stages. Uses obb_pkg.
`default_nettype none

module obb_proj #(
    parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF
) (
    input  wire logic                                             clk,
    input  wire obb_pkg::pipe_ctrl_t                              ctrl,
    input  wire logic signed [obb_pkg::vec_bits(COORD_BITS)-1:0]  ux,
    input  wire logic signed [obb_pkg::vec_bits(COORD_BITS)-1:0]  uy,
    input  wire logic signed [obb_pkg::vec_bits(COORD_BITS)-1:0]  vx,
    input  wire logic signed [obb_pkg::vec_bits(COORD_BITS)-1:0]  vy,
    input  wire logic signed [obb_pkg::DIFF_W-1:0]                dx,
    input  wire logic signed [obb_pkg::DIFF_W-1:0]                dy,
    input  wire logic        [obb_pkg::SIZE_W-1:0]                w,
    input  wire logic        [obb_pkg::SIZE_W-1:0]                h,
    output logic [obb_pkg::vec_bits(COORD_BITS)+obb_pkg::DIFF_W+3:0] rad_u,
    output logic [obb_pkg::vec_bits(COORD_BITS)+obb_pkg::DIFF_W+3:0] rad_v,
    output logic [obb_pkg::vec_bits(COORD_BITS)+obb_pkg::DIFF_W:0]   dist_u,
    output logic [obb_pkg::vec_bits(COORD_BITS)+obb_pkg::DIFF_W:0]   dist_v,
    output logic                                                     sep_aligned
);

    localparam int VW = obb_pkg::vec_bits(COORD_BITS);
    localparam int DW = obb_pkg::DIFF_W;
    localparam int MW = VW + DW;
    localparam int SW = MW + 4;
    localparam int AW = DW + 1;

    logic signed [MW-1:0] ux_e, uy_e, vx_e, vy_e, dx_e, dy_e, w_e, h_e;

    // Stage 3: projection products and aligned-axis test
    logic signed [MW-1:0] uux_reg, uuy_reg, vvx_reg, vvy_reg, uvx_reg, uvy_reg;
    logic signed [MW-1:0] uw_reg, uh_reg, vw_reg, vh_reg;
    logic signed [MW-1:0] udx_reg, udy_reg, vdx_reg, vdy_reg;
    logic                 sep3_reg, sep3_next;
    logic [VW-1:0]        aux, auy, avx, avy;
    logic [DW-1:0]        adx, ady;
    logic [AW-1:0]        rad_x, rad_y;

    // Stage 4: pair sums and magnitudes
    logic signed [MW:0]   uu_reg, vv_reg, dot_reg, ru_reg, rv_reg;
    logic [MW-1:0]        auw_reg, auh_reg, avw_reg, avh_reg;
    logic [MW-1:0]        auw_next, auh_next, avw_next, avh_next;
    logic                 sep4_reg;

    // Stage 5: radius sums and distances
    logic [SW-1:0]        su_reg, sv_reg, su_next, sv_next;
    logic [MW:0]          adot, aru_next, arv_next;
    logic [MW:0]          aru_reg, arv_reg;
    logic                 sep5_reg;

    always_comb
    begin
        ux_e = MW'(ux);
        uy_e = MW'(uy);
        vx_e = MW'(vx);
        vy_e = MW'(vy);
        dx_e = MW'(dx);
        dy_e = MW'(dy);
        w_e  = $signed(MW'(w));
        h_e  = $signed(MW'(h));
    end

    // Axes along x and y, divided through by the other box's size
    always_comb
    begin
        aux = ux[VW-1] ? VW'(-ux) : VW'(ux);
        auy = uy[VW-1] ? VW'(-uy) : VW'(uy);
        avx = vx[VW-1] ? VW'(-vx) : VW'(vx);
        avy = vy[VW-1] ? VW'(-vy) : VW'(vy);
        adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
        rad_x = (AW'(aux) << 1) + (AW'(avx) << 1) + AW'(w);
        rad_y = (AW'(auy) << 1) + (AW'(avy) << 1) + AW'(h);
        sep3_next = ((w != '0) && (rad_x < AW'(adx)))
                 || ((h != '0) && (rad_y < AW'(ady)));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[obb_pkg::ST_PROJ])
        begin
            uux_reg  <= ux_e * ux_e;
            uuy_reg  <= uy_e * uy_e;
            vvx_reg  <= vx_e * vx_e;
            vvy_reg  <= vy_e * vy_e;
            uvx_reg  <= ux_e * vx_e;
            uvy_reg  <= uy_e * vy_e;
            uw_reg   <= ux_e * w_e;
            uh_reg   <= uy_e * h_e;
            vw_reg   <= vx_e * w_e;
            vh_reg   <= vy_e * h_e;
            udx_reg  <= ux_e * dx_e;
            udy_reg  <= uy_e * dy_e;
            vdx_reg  <= vx_e * dx_e;
            vdy_reg  <= vy_e * dy_e;
            sep3_reg <= sep3_next;
        end
    end

    // Magnitudes of the cross-axis terms
    always_comb
    begin
        auw_next = uw_reg[MW-1] ? MW'(-uw_reg) : MW'(uw_reg);
        auh_next = uh_reg[MW-1] ? MW'(-uh_reg) : MW'(uh_reg);
        avw_next = vw_reg[MW-1] ? MW'(-vw_reg) : MW'(vw_reg);
        avh_next = vh_reg[MW-1] ? MW'(-vh_reg) : MW'(vh_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[obb_pkg::ST_PAIR])
        begin
            uu_reg   <= (MW+1)'(uux_reg) + (MW+1)'(uuy_reg);
            vv_reg   <= (MW+1)'(vvx_reg) + (MW+1)'(vvy_reg);
            dot_reg  <= (MW+1)'(uvx_reg) + (MW+1)'(uvy_reg);
            ru_reg   <= (MW+1)'(udx_reg) + (MW+1)'(udy_reg);
            rv_reg   <= (MW+1)'(vdx_reg) + (MW+1)'(vdy_reg);
            auw_reg  <= auw_next;
            auh_reg  <= auh_next;
            avw_reg  <= avw_next;
            avh_reg  <= avh_next;
            sep4_reg <= sep3_reg;
        end
    end

    // Radius sums at doubled scale and distance magnitudes
    always_comb
    begin
        adot     = dot_reg[MW] ? (MW+1)'(-dot_reg) : (MW+1)'(dot_reg);
        aru_next = ru_reg[MW] ? (MW+1)'(-ru_reg) : (MW+1)'(ru_reg);
        arv_next = rv_reg[MW] ? (MW+1)'(-rv_reg) : (MW+1)'(rv_reg);
        su_next  = (SW'(uu_reg[MW-1:0]) << 1) + (SW'(adot) << 1)
                 + SW'(auw_reg) + SW'(auh_reg);
        sv_next  = (SW'(vv_reg[MW-1:0]) << 1) + (SW'(adot) << 1)
                 + SW'(avw_reg) + SW'(avh_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[obb_pkg::ST_SUM])
        begin
            su_reg   <= su_next;
            sv_reg   <= sv_next;
            aru_reg  <= aru_next;
            arv_reg  <= arv_next;
            sep5_reg <= sep4_reg;
        end
    end

    assign rad_u       = su_reg;
    assign rad_v       = sv_reg;
    assign dist_u      = aru_reg;
    assign dist_v      = arv_reg;
    assign sep_aligned = sep5_reg;

endmodule

`default_nettype wire

@@ rtl/core/obb_overlap_test.sv @@
// Top level of the oriented box overlap test: configuration registers, pipeline
// control and final compare. Uses obb_pkg, obb_rot and obb_proj.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one box pair per beat: the
//   oriented box centre and unit direction, and the axis-aligned box corner
//   and size. Output channel (out_valid/out_ready) returns one overlap flag
//   per input beat, in order; touching boxes count as overlapping.
//   half_width and half_length are written through cfg_we/cfg_index/cfg_wdata
//   and apply to every later beat; unknown indexes are dropped.
//   One beat per cycle is accepted and delivered while out_ready stays high:
//   six register stages (extent multiply, round, projection multiply, pair
//   sums, radius sums, compare) each hold one item.
//   When out_ready is low the output register holds its beat; stages behind
//   it keep filling until every stage holds a beat, then in_ready drops.
//   Reset clears all stage valid bits and both extents to zero.
`default_nettype none

module obb_overlap_test #(
    parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [obb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [obb_pkg::EXT_W-1:0]            cfg_wdata,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [obb_pkg::COORD_W-1:0]   box_center_x,
    input  wire logic signed [obb_pkg::COORD_W-1:0]   box_center_y,
    input  wire logic signed [obb_pkg::DIR_W-1:0]     dir_cos,
    input  wire logic signed [obb_pkg::DIR_W-1:0]     dir_sin,
    input  wire logic signed [obb_pkg::COORD_W-1:0]   other_left_x,
    input  wire logic signed [obb_pkg::COORD_W-1:0]   other_top_y,
    input  wire logic        [obb_pkg::SIZE_W-1:0]    other_width,
    input  wire logic        [obb_pkg::SIZE_W-1:0]    other_height,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      overlap
);

    localparam int VW = obb_pkg::vec_bits(COORD_BITS);
    localparam int DW = obb_pkg::DIFF_W;
    localparam int MW = VW + DW;
    localparam int SW = MW + 4;
    localparam int NS = obb_pkg::NUM_STAGES;

    logic [obb_pkg::EXT_W-1:0] half_width_reg, half_length_reg;
    logic [NS-1:0]             valid_reg;
    logic [NS:0]               ready;
    obb_pkg::pipe_ctrl_t       ctrl;

    logic signed [VW-1:0]      ux, uy, vx, vy;
    logic signed [DW-1:0]      dx, dy;
    logic [obb_pkg::SIZE_W-1:0] w, h;
    logic [SW-1:0]             rad_u, rad_v;
    logic [MW:0]               dist_u, dist_v;
    logic                      sep_aligned;
    logic                      overlap_reg, overlap_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= '0;
            half_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                obb_pkg::REG_HALF_WIDTH:  half_width_reg  <= cfg_wdata;
                obb_pkg::REG_HALF_LENGTH: half_length_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its beat moves on
    always_comb
    begin
        ready[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        ctrl.load = ready[NS-1:0];
    end

    assign in_ready = ready[0];

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    obb_rot #(
        .COORD_BITS (COORD_BITS)
    ) u_rot (
        .clk          (clk),
        .ctrl         (ctrl),
        .half_width   (half_width_reg),
        .half_length  (half_length_reg),
        .box_center_x (box_center_x),
        .box_center_y (box_center_y),
        .dir_cos      (dir_cos),
        .dir_sin      (dir_sin),
        .other_left_x (other_left_x),
        .other_top_y  (other_top_y),
        .other_width  (other_width),
        .other_height (other_height),
        .ux           (ux),
        .uy           (uy),
        .vx           (vx),
        .vy           (vy),
        .dx           (dx),
        .dy           (dy),
        .w            (w),
        .h            (h)
    );

    obb_proj #(
        .COORD_BITS (COORD_BITS)
    ) u_proj (
        .clk         (clk),
        .ctrl        (ctrl),
        .ux          (ux),
        .uy          (uy),
        .vx          (vx),
        .vy          (vy),
        .dx          (dx),
        .dy          (dy),
        .w           (w),
        .h           (h),
        .rad_u       (rad_u),
        .rad_v       (rad_v),
        .dist_u      (dist_u),
        .dist_v      (dist_v),
        .sep_aligned (sep_aligned)
    );

    // Separated if any axis has its radius sum strictly below the distance
    always_comb
    begin
        overlap_next = !(sep_aligned
                      || (rad_u < SW'(dist_u))
                      || (rad_v < SW'(dist_v)));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[obb_pkg::ST_CMP])
        begin
            overlap_reg <= overlap_next;
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign overlap   = overlap_reg;

endmodule

`default_nettype wire

@@ bench/obb_checker.sv @@
// Checker for the oriented box overlap test: watches the config port and both
// channels, predicts each overlap flag and compares it in order.
// Depends on obb_pkg for field widths and register indexes.
module obb_checker #(
    parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [obb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [obb_pkg::EXT_W-1:0]            cfg_wdata,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic signed [obb_pkg::COORD_W-1:0]   box_center_x,
    input  logic signed [obb_pkg::COORD_W-1:0]   box_center_y,
    input  logic signed [obb_pkg::DIR_W-1:0]     dir_cos,
    input  logic signed [obb_pkg::DIR_W-1:0]     dir_sin,
    input  logic signed [obb_pkg::COORD_W-1:0]   other_left_x,
    input  logic signed [obb_pkg::COORD_W-1:0]   other_top_y,
    input  logic        [obb_pkg::SIZE_W-1:0]    other_width,
    input  logic        [obb_pkg::SIZE_W-1:0]    other_height,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic                                 overlap,
    output int                                   fail_count,
    output int                                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [obb_pkg::COORD_W-1:0] cx;
        logic signed [obb_pkg::COORD_W-1:0] cy;
        logic signed [obb_pkg::DIR_W-1:0]   c;
        logic signed [obb_pkg::DIR_W-1:0]   s;
        logic signed [obb_pkg::COORD_W-1:0] ox;
        logic signed [obb_pkg::COORD_W-1:0] oy;
        logic        [obb_pkg::SIZE_W-1:0]  w;
        logic        [obb_pkg::SIZE_W-1:0]  h;
        logic                               hit;
    } pair_rec_t;

    // Local copy of the extent registers
    logic [obb_pkg::EXT_W-1:0] ext_half_width;
    logic [obb_pkg::EXT_W-1:0] ext_half_length;

    // Predicted flags in arrival order
    pair_rec_t overlap_q[$];

    initial fail_count = 0;

    // Drop the Q1.14 fraction rounding half up, then clip to COORD_BITS signed
    function automatic longint scale_round(input longint p);
        longint r;
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        r = (p + 8192) >>> 14;
        if (r > hi)
            r = hi;
        if (r < lo)
            r = lo;
        return r;
    endfunction

    function automatic longint abs_l(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Projections are on doubled half-vectors, so the centre gap is doubled too
    function automatic bit axis_splits(input longint ax, input longint ay,
                                       input longint ux, input longint uy,
                                       input longint vx, input longint vy,
                                       input longint w, input longint h,
                                       input longint dx, input longint dy);
        longint reach;
        longint gap;
        reach = abs_l(ax * 2 * ux + ay * 2 * uy) + abs_l(ax * 2 * vx + ay * 2 * vy)
              + abs_l(ax * w) + abs_l(ay * h);
        gap = abs_l(ax * dx + ay * dy);
        return reach < gap;
    endfunction

    function automatic logic predict_overlap(input pair_rec_t p,
                                             input logic [obb_pkg::EXT_W-1:0] hw,
                                             input logic [obb_pkg::EXT_W-1:0] hl);
        longint len, wid, c, s, w, h;
        longint ux, uy, vx, vy, dx, dy;
        bit sep;
        len = longint'(hl);
        wid = longint'(hw);
        c = longint'(p.c);
        s = longint'(p.s);
        w = longint'(p.w);
        h = longint'(p.h);
        ux = scale_round(len * c);
        uy = scale_round(len * s);
        vx = scale_round(-(wid * s));
        vy = scale_round(wid * c);
        dx = 2 * longint'(p.ox) + w - 2 * longint'(p.cx);
        dy = 2 * longint'(p.oy) + h - 2 * longint'(p.cy);
        sep = axis_splits(ux, uy, ux, uy, vx, vy, w, h, dx, dy)
           || axis_splits(vx, vy, ux, uy, vx, vy, w, h, dx, dy)
           || axis_splits(w, 0, ux, uy, vx, vy, w, h, dx, dy)
           || axis_splits(0, h, ux, uy, vx, vy, w, h, dx, dy);
        return !sep;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("obb_checker: %0t: %s", $time, what);
    endtask

    // Track config, compare the outgoing beat, then predict the incoming one
    always @(posedge clk or negedge rst_n)
    begin
        pair_rec_t rec;
        pair_rec_t head;
        if (!rst_n)
        begin
            ext_half_width = '0;
            ext_half_length = '0;
            overlap_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    obb_pkg::REG_HALF_WIDTH:  ext_half_width = cfg_wdata;
                    obb_pkg::REG_HALF_LENGTH: ext_half_length = cfg_wdata;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (overlap_q.size() == 0)
                    report_mismatch($sformatf("overlap beat %b with nothing pending", overlap));
                else
                begin
                    head = overlap_q.pop_front();
                    if (overlap !== head.hit)
                        report_mismatch($sformatf(
                            "got %b want %b c=%0d,%0d dir=%0d,%0d o=%0d,%0d wh=%0d,%0d",
                            overlap, head.hit, head.cx, head.cy, head.c, head.s,
                            head.ox, head.oy, head.w, head.h));
                end
            end
            if (in_valid && in_ready)
            begin
                rec.cx = box_center_x;
                rec.cy = box_center_y;
                rec.c = dir_cos;
                rec.s = dir_sin;
                rec.ox = other_left_x;
                rec.oy = other_top_y;
                rec.w = other_width;
                rec.h = other_height;
                rec.hit = predict_overlap(rec, ext_half_width, ext_half_length);
                overlap_q = {overlap_q, rec};
            end
            pending <= overlap_q.size();
        end
    end

endmodule

@@ bench/tb.sv @@
// Testbench top for the oriented box overlap test: clock, reset, config writes,
// box pair stimulus with idle phases, and the verdict.
// Depends on obb_pkg, obb_overlap_test and obb_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 200;
    localparam int BURST_ITEMS = 30;
    localparam int TAIL_CYCLES = 20;

    // Indexes past the register list, written to check they are dropped
    localparam logic [obb_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [obb_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        int cx;
        int cy;
        int c;
        int s;
        int ox;
        int oy;
        int w;
        int h;
    } box_pair_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_we;
    logic [obb_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [obb_pkg::EXT_W-1:0]            cfg_wdata;
    logic                                 in_valid;
    logic                                 in_ready;
    logic signed [obb_pkg::COORD_W-1:0]   box_center_x;
    logic signed [obb_pkg::COORD_W-1:0]   box_center_y;
    logic signed [obb_pkg::DIR_W-1:0]     dir_cos;
    logic signed [obb_pkg::DIR_W-1:0]     dir_sin;
    logic signed [obb_pkg::COORD_W-1:0]   other_left_x;
    logic signed [obb_pkg::COORD_W-1:0]   other_top_y;
    logic        [obb_pkg::SIZE_W-1:0]    other_width;
    logic        [obb_pkg::SIZE_W-1:0]    other_height;
    logic                                 out_valid;
    logic                                 out_ready;
    logic                                 overlap;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_token = 0;
    int cur_hw = 0;
    int cur_hl = 0;

    obb_overlap_test dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .box_center_x (box_center_x),
        .box_center_y (box_center_y),
        .dir_cos      (dir_cos),
        .dir_sin      (dir_sin),
        .other_left_x (other_left_x),
        .other_top_y  (other_top_y),
        .other_width  (other_width),
        .other_height (other_height),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .overlap      (overlap)
    );

    obb_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .box_center_x (box_center_x),
        .box_center_y (box_center_y),
        .dir_cos      (dir_cos),
        .dir_sin      (dir_sin),
        .other_left_x (other_left_x),
        .other_top_y  (other_top_y),
        .other_width  (other_width),
        .other_height (other_height),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .overlap      (overlap),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Abort a run that hangs
    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
            @(posedge clk);
        $display("tb: FAIL");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off each time the token moves
    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic signed [15:0] clamp_coord(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic box_pair_t make_pair(input int cx, input int cy, input int c,
                                            input int s, input int ox, input int oy,
                                            input int w, input int h);
        box_pair_t p;
        p.cx = cx;
        p.cy = cy;
        p.c = c;
        p.s = s;
        p.ox = ox;
        p.oy = oy;
        p.w = w;
        p.h = h;
        return p;
    endfunction

    // Near pairs scaled to the extents, edge contacts or one-LSB gaps,
    // some degenerate axes, and some fully random fields
    function automatic box_pair_t random_pair(input int hw, input int hl);
        box_pair_t p;
        int pick, sub, ext, span, xh, yh, delta;
        int cx, cy, c, s, ox, oy, w, h, mag_s;
        pick = $urandom_range(99);
        ext = hw + hl;
        cx = int'($urandom_range(16000)) - 8000;
        cy = int'($urandom_range(16000)) - 8000;
        w = $urandom_range(ext / 2 + 2000);
        h = $urandom_range(ext / 2 + 2000);
        c = int'($urandom_range(32768)) - 16384;
        mag_s = $rtoi($sqrt(268435456.0 - real'(c) * real'(c)));
        s = ($urandom_range(1) == 1) ? mag_s : -mag_s;
        span = ext + (w + h) / 2 + 500;
        ox = cx - w / 2 + int'($urandom_range(2 * span)) - span;
        oy = cy - h / 2 + int'($urandom_range(2 * span)) - span;
        if (pick >= 45 && pick < 65)
        begin
            case ($urandom_range(3))
                0: begin c = 16384;  s = 0;      end
                1: begin c = -16384; s = 0;      end
                2: begin c = 0;      s = 16384;  end
                default: begin c = 0; s = -16384; end
            endcase
            xh = (s == 0) ? hl : hw;
            yh = (s == 0) ? hw : hl;
            delta = $urandom_range(1);
            case ($urandom_range(3))
                0: begin ox = cx + xh + delta;     oy = cy - h / 2; end
                1: begin ox = cx - xh - w - delta; oy = cy - h / 2; end
                2: begin oy = cy + yh + delta;     ox = cx - w / 2; end
                default: begin oy = cy - yh - h - delta; ox = cx - w / 2; end
            endcase
        end
        else if (pick >= 65 && pick < 80)
        begin
            sub = $urandom_range(3);
            if (sub == 0)
            begin
                c = 0;
                s = 0;
            end
            else if (sub == 1)
            begin
                c = int'($urandom_range(65535)) - 32768;
                s = int'($urandom_range(65535)) - 32768;
            end
            else if (sub == 2)
                w = 0;
            else
                h = 0;
        end
        else if (pick >= 80)
        begin
            cx = int'($urandom_range(65535)) - 32768;
            cy = int'($urandom_range(65535)) - 32768;
            c = int'($urandom_range(65535)) - 32768;
            s = int'($urandom_range(65535)) - 32768;
            ox = int'($urandom_range(65535)) - 32768;
            oy = int'($urandom_range(65535)) - 32768;
            w = $urandom_range(32767);
            h = $urandom_range(32767);
        end
        p = make_pair(clamp_coord(cx), clamp_coord(cy), c, s,
                      clamp_coord(ox), clamp_coord(oy), w, h);
        return p;
    endfunction

    // Offer one pair, hold it until accepted, then idle at random
    task automatic drive_pair(input box_pair_t p);
        box_center_x <= p.cx[15:0];
        box_center_y <= p.cy[15:0];
        dir_cos <= p.c[15:0];
        dir_sin <= p.s[15:0];
        other_left_x <= p.ox[15:0];
        other_top_y <= p.oy[15:0];
        other_width <= p.w[14:0];
        other_height <= p.h[14:0];
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop offering and wait until every predicted flag has come back
    task automatic pause_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [obb_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[obb_pkg::EXT_W-1:0];
        @(posedge clk);
    endtask

    // Load both extents and poke a spare index with junk
    task automatic load_extents(input int hw, input int hl);
        write_reg(obb_pkg::REG_HALF_WIDTH, hw);
        write_reg(obb_pkg::REG_HALF_LENGTH, hl);
        write_reg(($urandom_range(1) == 1) ? REG_SPARE_A : REG_SPARE_B,
                  $urandom_range(16383));
        cfg_we <= 1'b0;
        cur_hw = hw;
        cur_hl = hl;
    endtask

    initial
    begin : stimulus
        int phase;
        int hw;
        int hl;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= obb_pkg::REG_HALF_WIDTH;
        cfg_wdata <= '0;
        in_valid <= 1'b0;
        box_center_x <= '0;
        box_center_y <= '0;
        dir_cos <= '0;
        dir_sin <= '0;
        other_left_x <= '0;
        other_top_y <= '0;
        other_width <= '0;
        other_height <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extents at reset value: the oriented box is a point
        drive_pair(make_pair(0, 0, 16384, 0, -100, -100, 200, 200));
        drive_pair(make_pair(100, 0, 16384, 0, -100, -100, 200, 200));
        drive_pair(make_pair(101, 0, 16384, 0, -100, -100, 200, 200));
        drive_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));

        // Moderate extents: edge contact, rotation, degenerate axes, extremes
        pause_for_results();
        load_extents(800, 1600);
        drive_pair(make_pair(0, 0, 16384, 0, 1600, -400, 800, 800));
        drive_pair(make_pair(0, 0, 16384, 0, 1601, -400, 800, 800));
        drive_pair(make_pair(0, 0, 11585, 11585, 1000, 1000, 400, 400));
        drive_pair(make_pair(0, 0, 0, 0, -10, -10, 20, 20));
        drive_pair(make_pair(0, 0, 0, 0, 5000, -10, 20, 20));
        drive_pair(make_pair(0, 0, 16384, 0, 100, -50, 0, 100));
        drive_pair(make_pair(0, 0, 16384, 0, -50, 100, 100, 0));
        drive_pair(make_pair(0, 0, 16384, 0, 0, 0, 0, 0));
        drive_pair(make_pair(0, 0, -32768, -32768, 500, 500, 100, 100));
        drive_pair(make_pair(0, 0, 32767, 32767, -3000, 2000, 100, 100));
        drive_pair(make_pair(-32768, -32768, 16384, 0, 32767, 32767, 32767, 32767));
        drive_pair(make_pair(32767, 32767, -16384, 0, -32768, -32768, 32767, 32767));
        drive_pair(make_pair(32767, -32768, 0, -16384, -32768, 32767, 0, 0));
        drive_pair(make_pair(0, 0, 16384, -16384, 2000, -2000, 300, 300));

        // Largest extents: rotation near saturation and contact at the far edge
        pause_for_results();
        load_extents(16383, 16383);
        drive_pair(make_pair(0, 0, -32768, 32767, 0, 0, 1, 1));
        drive_pair(make_pair(0, 0, 32767, -32768, -32768, -32768, 0, 32767));
        drive_pair(make_pair(0, 0, -16384, 0, 16383, 0, 10, 10));
        drive_pair(make_pair(0, 0, -16384, 0, 16384, 0, 10, 10));

        // Long hold-off on the output while pairs keep coming back to back
        pause_for_results();
        send_idle_pct = 0;
        stall_pct <= 0;
        hold_token <= hold_token + 1;
        repeat (BURST_ITEMS)
            drive_pair(random_pair(cur_hw, cur_hl));

        // Random phases over extent settings and idle patterns
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin hw = 16383; hl = 16383; end
                1: begin hw = 0;     hl = 16383; end
                2: begin hw = 16383; hl = 0;     end
                3: begin hw = 0;     hl = 0;     end
                7: begin hw = $urandom_range(400);  hl = $urandom_range(400);  end
                default: begin hw = $urandom_range(4000); hl = $urandom_range(4000); end
            endcase
            pause_for_results();
            load_extents(hw, hl);
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 70; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 70; end
                default: begin send_idle_pct = 12; stall_pct <= 12; end
            endcase
            repeat (PHASE_ITEMS)
                drive_pair(random_pair(cur_hw, cur_hl));
        end

        // Drain, let any stray beat show up, then decide
        pause_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
